@@ rtl/clfs_pkg.sv @@
package clfs_pkg;

  // Item kinds
  localparam logic [1:0] KIND_REMOTE = 2'd0;
  localparam logic [1:0] KIND_WIFI   = 2'd1;
  localparam logic [1:0] KIND_TICK   = 2'd2;

  // Link levels
  localparam logic [1:0] LEVEL_FRESH = 2'd0;
  localparam logic [1:0] LEVEL_STALE = 2'd1;
  localparam logic [1:0] LEVEL_LOST  = 2'd2;

  // Sources
  localparam logic SRC_REMOTE = 1'b0;
  localparam logic SRC_WIFI   = 1'b1;

  // Register indexes
  localparam logic [2:0] REG_STALE_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_LOST_TIMEOUT  = 3'd1;
  localparam logic [2:0] REG_SMOOTH_GAIN   = 3'd2;
  localparam logic [2:0] REG_MIN_THRUST    = 3'd3;
  localparam logic [2:0] REG_MAX_THRUST    = 3'd4;

  // Register reset values
  localparam logic [15:0] STALE_TIMEOUT_RST = 16'd500;
  localparam logic [15:0] LOST_TIMEOUT_RST  = 16'd1000;
  localparam logic [15:0] SMOOTH_GAIN_RST   = 16'd13107;
  localparam logic [15:0] MIN_THRUST_RST    = 16'd5000;
  localparam logic [15:0] MAX_THRUST_RST    = 16'd60000;

  localparam int TICK_BITS_DEF = 32;

endpackage

@@ rtl/command_link_failsafe_smoother_top.sv @@
// Command link failsafe smoother.
//
// Input channel (in_valid_i / in_ready_o): one transfer is a remote packet,
// a wifi packet or an update tick, told apart by kind_i. Packets are stored
// as the latest command of their source together with now_tick_i; they make
// no result. Kind 3 is dropped. Each update tick makes exactly one result on
// the output channel (out_valid_o / out_ready_i).
// Config port: cfg_we_i writes cfg_data_i into register cfg_idx_i at once;
// indexes above 4 are ignored. Write only while the block is idle.
//
// Path: a tick is captured in the input register, then passes through the
// age/pick/filter logic into the result register.
// Throughput: one transfer per cycle while no tick waits on a stalled result;
// the four filter multipliers work in parallel inside the single compute stage.
// Reset: registers to their defaults, both stamps and all commands zero,
// filters and held trims zero, link unlocked, no result pending.
// Output stall: the result holds; packets still move through the input
// stage, and the next tick waits in it until the result is taken.
module command_link_failsafe_smoother_top
  import clfs_pkg::*;
#(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         kind_i,
  input  logic [31:0]        now_tick_i,
  input  logic [15:0]        cmd_thrust_i,
  input  logic signed [15:0] cmd_pitch_i,
  input  logic signed [15:0] cmd_roll_i,
  input  logic signed [15:0] cmd_yaw_i,
  input  logic signed [15:0] cmd_trim_pitch_i,
  input  logic signed [15:0] cmd_trim_roll_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [15:0]        out_thrust_o,
  output logic signed [15:0] out_pitch_o,
  output logic signed [15:0] out_roll_o,
  output logic signed [15:0] out_yaw_o,
  output logic signed [15:0] out_trim_pitch_o,
  output logic signed [15:0] out_trim_roll_o,
  output logic               locked_o,
  output logic               chosen_source_o,
  output logic [1:0]         link_level_o
);

  typedef struct packed {
    logic [15:0] thrust;
    logic [15:0] pitch;
    logic [15:0] roll;
    logic [15:0] yaw;
    logic [15:0] trim_pitch;
    logic [15:0] trim_roll;
  } cmd_t;

  // One filter step: base + round_half_up((target*256 - base) * gain / 2^16)
  function automatic logic signed [24:0] smooth_step(input logic signed [24:0] diff,
                                                     input logic [15:0] gain);
    logic signed [41:0] prod;
    prod = diff * $signed({1'b0, gain});
    prod = prod + 42'sd32768;
    return prod[40:16];
  endfunction

  function automatic logic [23:0] smooth_signed(input logic [23:0] base,
                                                input logic [15:0] tgt,
                                                input logic [15:0] gain);
    logic signed [24:0] base_x;
    logic signed [24:0] diff;
    logic signed [24:0] sum;
    base_x = $signed({base[23], base});
    diff   = $signed({tgt[15], tgt, 8'h00}) - base_x;
    sum    = base_x + smooth_step(diff, gain);
    return sum[23:0];
  endfunction

  // Config registers
  logic [15:0] stale_q, lost_q, gain_q, min_q, max_q;

  // Input stage
  logic                 s1_valid_q;
  logic [1:0]           s1_kind_q;
  logic [TICK_BITS-1:0] s1_now_q;
  cmd_t                 s1_cmd_q;
  logic [TICK_BITS+31:0] now_wide;

  // Per-source state
  logic [TICK_BITS-1:0] stamp_q [2];
  cmd_t                 src_cmd_q [2];

  // Filter state
  logic [23:0] filt_thr_q, filt_thr_d;
  logic [23:0] filt_pitch_q, filt_pitch_d;
  logic [23:0] filt_roll_q, filt_roll_d;
  logic [23:0] filt_yaw_q, filt_yaw_d;
  logic [15:0] trim_pitch_q, trim_pitch_d;
  logic [15:0] trim_roll_q, trim_roll_d;
  logic        lock_q, lock_d;

  // Result side
  logic       out_valid_q;
  logic       src_q, src_d;
  logic [1:0] level_q, level_d;

  // Compute stage
  logic                  s1_go, s1_tick, s1_pkt;
  logic [TICK_BITS+15:0] stale_wide, lost_wide;
  logic [TICK_BITS-1:0]  stale_t, lost_t, age0, age1;
  cmd_t                  pick;
  logic [23:0]           thr_base, pitch_base, roll_base, yaw_base;
  logic signed [24:0]    thr_diff, thr_sum;
  logic [23:0]           thr_new, thr_lo, thr_hi;

  assign now_wide   = {TICK_BITS'(0), now_tick_i};
  assign stale_wide = {TICK_BITS'(0), stale_q};
  assign lost_wide  = {TICK_BITS'(0), lost_q};
  assign stale_t    = stale_wide[TICK_BITS-1:0];
  assign lost_t     = lost_wide[TICK_BITS-1:0];

  assign s1_tick = s1_valid_q && (s1_kind_q == KIND_TICK);
  assign s1_pkt  = s1_valid_q && ((s1_kind_q == KIND_REMOTE) || (s1_kind_q == KIND_WIFI));
  // A tick may only leave the input stage when the result slot is free
  assign s1_go      = s1_valid_q && (!s1_tick || !out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_go;

  always_comb begin
    age0 = s1_now_q - stamp_q[0];
    age1 = s1_now_q - stamp_q[1];

    lock_d  = lock_q;
    src_d   = SRC_REMOTE;
    level_d = LEVEL_LOST;
    if (age0 < stale_t) begin
      src_d   = SRC_REMOTE;
      level_d = LEVEL_FRESH;
      lock_d  = 1'b0;
    end else if (age1 < stale_t) begin
      src_d   = SRC_WIFI;
      level_d = LEVEL_FRESH;
      lock_d  = 1'b0;
    end else if (age0 < lost_t) begin
      src_d   = SRC_REMOTE;
      level_d = LEVEL_STALE;
    end else if (age1 < lost_t) begin
      src_d   = SRC_WIFI;
      level_d = LEVEL_STALE;
    end else begin
      lock_d  = 1'b1;
    end

    pick = src_cmd_q[src_d];

    // Leveling on stale, dropping on loss
    thr_base   = (level_d == LEVEL_LOST) ? 24'd0 : filt_thr_q;
    pitch_base = (level_d == LEVEL_FRESH) ? filt_pitch_q : 24'd0;
    roll_base  = (level_d == LEVEL_FRESH) ? filt_roll_q : 24'd0;
    yaw_base   = (level_d == LEVEL_FRESH) ? filt_yaw_q : 24'd0;

    thr_diff = $signed({1'b0, pick.thrust, 8'h00}) - $signed({1'b0, thr_base});
    thr_sum  = $signed({1'b0, thr_base}) + smooth_step(thr_diff, gain_q);
    thr_new  = thr_sum[23:0];
    thr_lo   = {min_q, 8'h00};
    thr_hi   = {max_q, 8'h00};
    if (thr_new < thr_lo) begin
      thr_new = 24'd0;
    end else if (thr_new >= thr_hi) begin
      thr_new = thr_hi;
    end

    if (!lock_d) begin
      filt_thr_d   = thr_new;
      filt_pitch_d = smooth_signed(pitch_base, pick.pitch, gain_q);
      filt_roll_d  = smooth_signed(roll_base, pick.roll, gain_q);
      filt_yaw_d   = smooth_signed(yaw_base, pick.yaw, gain_q);
      trim_pitch_d = pick.trim_pitch;
      trim_roll_d  = pick.trim_roll;
    end else begin
      filt_thr_d   = thr_base;
      filt_pitch_d = pitch_base;
      filt_roll_d  = roll_base;
      filt_yaw_d   = yaw_base;
      trim_pitch_d = trim_pitch_q;
      trim_roll_d  = trim_roll_q;
    end
  end

  // Config writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q <= STALE_TIMEOUT_RST;
      lost_q  <= LOST_TIMEOUT_RST;
      gain_q  <= SMOOTH_GAIN_RST;
      min_q   <= MIN_THRUST_RST;
      max_q   <= MAX_THRUST_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_STALE_TIMEOUT: stale_q <= cfg_data_i;
        REG_LOST_TIMEOUT:  lost_q  <= cfg_data_i;
        REG_SMOOTH_GAIN:   gain_q  <= cfg_data_i;
        REG_MIN_THRUST:    min_q   <= cfg_data_i;
        REG_MAX_THRUST:    max_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_kind_q <= kind_i;
      s1_now_q  <= now_wide[TICK_BITS-1:0];
      s1_cmd_q  <= '{thrust:     cmd_thrust_i,
                     pitch:      cmd_pitch_i,
                     roll:       cmd_roll_i,
                     yaw:        cmd_yaw_i,
                     trim_pitch: cmd_trim_pitch_i,
                     trim_roll:  cmd_trim_roll_i};
    end
  end

  // Per-source latest packet
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q[0]   <= '0;
      stamp_q[1]   <= '0;
      src_cmd_q[0] <= '0;
      src_cmd_q[1] <= '0;
    end else if (s1_go && s1_pkt) begin
      stamp_q[s1_kind_q[0]]   <= s1_now_q;
      src_cmd_q[s1_kind_q[0]] <= s1_cmd_q;
    end
  end

  // Filter state and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      filt_thr_q   <= '0;
      filt_pitch_q <= '0;
      filt_roll_q  <= '0;
      filt_yaw_q   <= '0;
      trim_pitch_q <= '0;
      trim_roll_q  <= '0;
      lock_q       <= 1'b0;
      src_q        <= SRC_REMOTE;
      level_q      <= LEVEL_FRESH;
    end else if (s1_go && s1_tick) begin
      filt_thr_q   <= filt_thr_d;
      filt_pitch_q <= filt_pitch_d;
      filt_roll_q  <= filt_roll_d;
      filt_yaw_q   <= filt_yaw_d;
      trim_pitch_q <= trim_pitch_d;
      trim_roll_q  <= trim_roll_d;
      lock_q       <= lock_d;
      src_q        <= src_d;
      level_q      <= level_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_go && s1_tick) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Filter state only moves on a tick, and a tick waits while a result is
  // pending, so the state registers double as the result payload.
  assign out_valid_o      = out_valid_q;
  assign out_thrust_o     = filt_thr_q[23:8];
  assign out_pitch_o      = filt_pitch_q[23:8];
  assign out_roll_o       = filt_roll_q[23:8];
  assign out_yaw_o        = filt_yaw_q[23:8];
  assign out_trim_pitch_o = trim_pitch_q;
  assign out_trim_roll_o  = trim_roll_q;
  assign locked_o         = lock_q;
  assign chosen_source_o  = src_q;
  assign link_level_o     = level_q;

endmodule

@@ rtl/clfs_checker.sv @@
module clfs_checker
  import clfs_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [15:0] out_thrust_i,
  input logic [15:0] out_pitch_i,
  input logic [15:0] out_roll_i,
  input logic [15:0] out_yaw_i,
  input logic        locked_i,
  input logic        chosen_source_i,
  input logic [1:0]  link_level_i
);

  // Stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_thrust_i) &&
      $stable(out_pitch_i) && $stable(link_level_i) && $stable(locked_i))
    else $error("stalled result changed");

  // Loss locks, drops thrust and attitude to zero and picks the remote source
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (link_level_i == LEVEL_LOST) |-> locked_i &&
      (out_thrust_i == 16'd0) && (out_pitch_i == 16'd0) && (out_roll_i == 16'd0) &&
      (out_yaw_i == 16'd0) && (chosen_source_i == SRC_REMOTE))
    else $error("lost link not dropped");

  // A fresh source always unlocks
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (link_level_i == LEVEL_FRESH) |-> !locked_i)
    else $error("fresh link still locked");

  // Stale while locked levels the attitude
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (link_level_i == LEVEL_STALE) && locked_i |->
      (out_pitch_i == 16'd0) && (out_roll_i == 16'd0) && (out_yaw_i == 16'd0))
    else $error("stale locked attitude not level");

endmodule

bind command_link_failsafe_smoother_top clfs_checker u_clfs_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_i     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .out_thrust_i    (out_thrust_o),
  .out_pitch_i     (out_pitch_o),
  .out_roll_i      (out_roll_o),
  .out_yaw_i       (out_yaw_o),
  .locked_i        (locked_o),
  .chosen_source_i (chosen_source_o),
  .link_level_i    (link_level_o)
);
